/* sv/sha256_digest_check_core_macros.svh */
// ----------------------------------------------------------------------------
// sha256 digest check assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SHA256_DIGEST_CHECK_CORE_MACROS_SVH
`define SHA256_DIGEST_CHECK_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SDC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* sv/sdc_pkg.sv */
// ----------------------------------------------------------------------------
// sha256 digest check package
// state type, round constants and round helpers
// ----------------------------------------------------------------------------
package sdc_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_OUT
   } state_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   typedef logic [31:0] word_type;

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type rotr(word_type x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

/* sv/sha256_digest_check_core.sv */
// ----------------------------------------------------------------------------
// sha256 digest check core
// byte-wide sha-256 with one shared round unit and a digest compare
// ----------------------------------------------------------------------------
//  channel | dir | ports
//  req     | in  | req_valid, req_stall, req_message_byte, req_has_byte, req_last_byte
//  rsp     | out | rsp_valid, rsp_stall, rsp_digest_word, rsp_word_index, ...
//  csr     | in  | csr_write, csr_index, csr_data
//
//  a byte that fills a block starts 64 rounds and a hash update
//  a last beat then adds one or two padded blocks, then 8 rsp beats
//  the round unit is the bottleneck; rsp stall holds the word sequencer
//  synchronous reset loads the initial hash and clears all counters
module sha256_digest_check_core
   import sdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_message_byte,
   input  logic        req_has_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word,
   output logic        rsp_digest_matches,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   state_type state_ff, state_in;
   logic [31:0] buf_ff [16];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   word_type    hash_ff [8];
   word_type    v_ff [8];
   word_type    w_ff [16];
   logic [5:0]  rnd_ff, rnd_in;
   logic        final_ff, final_in;  // compressing padded data
   logic        two_ff, two_in;      // padding spans two blocks
   logic        tail_ff, tail_in;    // current block is the length block
   logic [2:0]  widx_ff, widx_in;
   logic [63:0] exp_ff [4];
   logic        match_ff;

   logic        accept, byte_in, start_blk, start_pad;
   word_type    w_cur, t1, t2, s0, s1, ch, mj, sg0, sg1;
   logic [5:0]  bi;
   logic [7:0]  pb [4];

   assign accept = req_valid && !req_stall;
   assign byte_in = accept && req_has_byte;

   // byte source for message words, with padding in final blocks
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         bi = {rnd_ff[3:0], 2'(k)};
         if (!final_ff || (!(tail_ff && two_ff) && bi < fill_ff))
            pb[k] = buf_ff[rnd_ff[3:0]][8*(3 - k) +: 8];
         else if (!(tail_ff && two_ff) && bi == fill_ff)
            pb[k] = PAD_BYTE;
         else if (tail_ff && bi >= LEN_POS)
            pb[k] = bits_ff[8*(63 - 32'(bi)) +: 8];
         else
            pb[k] = 8'h00;
      end
   end

   always_comb begin
      sg0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      sg1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      if (rnd_ff < 6'd16) w_cur = {pb[0], pb[1], pb[2], pb[3]};
      else w_cur = w_ff[0] + sg0 + w_ff[9] + sg1;
      s1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + s1 + ch + ROUND_K[rnd_ff] + w_cur;
      s0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = s0 + mj;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_has_byte && fill_ff == 6'd63) state_in = ST_ROUND;
            else if (accept && req_last_byte) state_in = ST_PAD;
         end
         ST_ROUND: if (rnd_ff == 6'd63) state_in = ST_ADD;
         ST_ADD: begin
            if (final_ff && tail_ff) state_in = ST_OUT;
            else if (final_ff || two_ff) state_in = ST_PAD;
            else state_in = ST_IDLE;
         end
         ST_PAD: state_in = ST_ROUND;
         ST_OUT: if (!rsp_stall && widx_ff == 3'd7) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign start_blk = state_ff == ST_IDLE && byte_in && fill_ff == 6'd63;
   assign start_pad = state_ff == ST_PAD;

   // outputs and control updates
   always_comb begin
      req_stall = state_ff != ST_IDLE;
      rsp_valid = state_ff == ST_OUT;
      fill_in = fill_ff;
      bits_in = bits_ff;
      rnd_in = rnd_ff;
      final_in = final_ff;
      two_in = two_ff;
      tail_in = tail_ff;
      widx_in = widx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (byte_in) begin
               fill_in = fill_ff + 6'd1;
               bits_in = bits_ff + 64'd8;
            end
            if (accept && req_last_byte) begin
               // pending last is kept in two_ff until the block is done
               two_in = 1'b1;
               final_in = 1'b0;
            end
            rnd_in = 6'd0;
         end
         ST_ROUND: rnd_in = rnd_ff + 6'd1;
         ST_ADD: begin
            if (final_ff && tail_ff) begin
               widx_in = 3'd0;
               final_in = 1'b0;
               two_in = 1'b0;
               tail_in = 1'b0;
               fill_in = 6'd0;
               bits_in = 64'd0;
            end else if (final_ff && !tail_ff) begin
               tail_in = 1'b1;
            end
         end
         ST_PAD: begin
            rnd_in = 6'd0;
            if (!final_ff) begin
               final_in = 1'b1;
               tail_in = fill_ff < LEN_POS;
               two_in = fill_ff >= LEN_POS;
            end
         end
         ST_OUT: if (!rsp_stall) widx_in = widx_ff + 3'd1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff <= '0;
         bits_ff <= '0;
         rnd_ff <= '0;
         final_ff <= 1'b0;
         two_ff <= 1'b0;
         tail_ff <= 1'b0;
         widx_ff <= '0;
         for (int k = 0; k < 4; k++) exp_ff[k] <= '0;
         for (int k = 0; k < 8; k++) hash_ff[k] <= INIT_HASH[k];
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         rnd_ff <= rnd_in;
         final_ff <= final_in;
         two_ff <= two_in;
         tail_ff <= tail_in;
         widx_ff <= widx_in;
         if (csr_write) exp_ff[csr_index] <= csr_data;
         if (state_ff == ST_ADD) begin
            for (int k = 0; k < 8; k++) hash_ff[k] <= hash_ff[k] + v_ff[k];
         end
         if (state_ff == ST_OUT && !rsp_stall && widx_ff == 3'd7) begin
            for (int k = 0; k < 8; k++) hash_ff[k] <= INIT_HASH[k];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (byte_in && state_ff == ST_IDLE)
         buf_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= req_message_byte;
      if (start_blk || start_pad) begin
         for (int k = 0; k < 8; k++) v_ff[k] <= hash_ff[k];
      end else if (state_ff == ST_ROUND) begin
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         for (int k = 0; k < 15; k++) w_ff[k] <= w_ff[k+1];
         w_ff[15] <= w_cur;
      end
      if (state_ff == ST_ADD) begin
         match_ff <= {hash_ff[0] + v_ff[0], hash_ff[1] + v_ff[1]} == exp_ff[0] &&
                     {hash_ff[2] + v_ff[2], hash_ff[3] + v_ff[3]} == exp_ff[1] &&
                     {hash_ff[4] + v_ff[4], hash_ff[5] + v_ff[5]} == exp_ff[2] &&
                     {hash_ff[6] + v_ff[6], hash_ff[7] + v_ff[7]} == exp_ff[3];
      end
   end

   assign rsp_digest_word = hash_ff[widx_ff];
   assign rsp_word_index = widx_ff;
   assign rsp_last_word = widx_ff == 3'd7;
   assign rsp_digest_matches = match_ff;

endmodule

/* sv/sdc_checker.sv */
// ----------------------------------------------------------------------------
// sha256 digest check port checker
// port-level properties bound to the core
// ----------------------------------------------------------------------------
`include "sha256_digest_check_core_macros.svh"

module sdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   `SDC_ASSERT_IMP(a_no_req_during_rsp, clock, reset, rsp_valid, req_stall)
   `SDC_ASSERT_IMP(a_last_tag, clock, reset, rsp_valid, rsp_last_word == (rsp_word_index == 3'd7))
   `SDC_ASSERT_NEXT(a_word_step, clock, reset, rsp_valid && !rsp_stall && !rsp_last_word, rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
   `SDC_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_digest_word))

endmodule

bind sha256_digest_check_core sdc_checker u_sdc_checker (.*);

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// sha256 digest check testbench
// drives byte beats through the core and checks every digest word against
// an in-bench sha-256 predictor, including the digest compare flag, under
// several phases of sender idling and receiver stalls
// ----------------------------------------------------------------------------
module tb
   import sdc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REG_DIGEST_0 = 2'd0;
   localparam logic [1:0] REG_DIGEST_1 = 2'd1;
   localparam logic [1:0] REG_DIGEST_2 = 2'd2;
   localparam logic [1:0] REG_DIGEST_3 = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      word_type   word;
      logic [2:0] index;
      logic       last;
      logic       match_flag;
   } digest_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_message_byte = '0;
   logic        req_has_byte = 1'b0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   logic        rsp_digest_matches;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   digest_beat_type digest_q[$];
   word_type     hash_st[8];
   logic [7:0]   block_st[64];
   int           fill_st;
   logic [63:0]  bit_len_st;
   logic [63:0]  expected_st[4];
   word_type     last_digest[8];
   int           gap_pct = 0;
   int           stall_pct = 0;
   int           errors = 0;
   int           beats_sent = 0;
   int           cycles = 0;

   sha256_digest_check_core u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_message_byte, .req_has_byte,
      .req_last_byte, .rsp_valid, .rsp_stall, .rsp_digest_word, .rsp_word_index,
      .rsp_last_word, .rsp_digest_matches, .csr_write, .csr_index, .csr_data
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic word_type ror(word_type x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void compress_block(logic [7:0] blk[64]);
      word_type w[64];
      word_type v[8];
      word_type t1, t2;
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
         end else begin
            w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
         end
      end
      for (int i = 0; i < 8; i++) v[i] = hash_st[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_st[i] += v[i];
   endfunction

   function automatic void restart_hash();
      for (int i = 0; i < 8; i++) hash_st[i] = INIT_HASH[i];
      fill_st = 0;
      bit_len_st = '0;
   endfunction

   function automatic void predict_digest(logic [7:0] b, logic has, logic last);
      logic [7:0] tail[64];
      logic       all_eq;
      word_type   ex;
      if (has) begin
         block_st[fill_st] = b;
         fill_st++;
         bit_len_st += 64'd8;
         if (fill_st == 64) begin
            compress_block(block_st);
            fill_st = 0;
         end
      end
      if (!last) return;
      for (int i = 0; i < 64; i++) tail[i] = (i < fill_st) ? block_st[i] : 8'h00;
      tail[fill_st] = PAD_BYTE;
      if (fill_st >= LEN_POS) begin
         compress_block(tail);
         for (int i = 0; i < 64; i++) tail[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) tail[63-i] = bit_len_st[8*i +: 8];
      compress_block(tail);
      all_eq = 1'b1;
      for (int i = 0; i < 8; i++) begin
         ex = (i % 2 == 0) ? expected_st[i/2][63:32] : expected_st[i/2][31:0];
         if (ex != hash_st[i]) all_eq = 1'b0;
      end
      for (int i = 0; i < 8; i++) begin
         digest_q.push_back('{hash_st[i], 3'(i), i == 7, all_eq});
         last_digest[i] = hash_st[i];
      end
      restart_hash();
   endfunction

   // result side: check each accepted beat, stall at random
   always @(posedge clock) begin
      digest_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_q.size() == 0) begin
            $error("digest word with no expectation: %h", rsp_digest_word);
            errors++;
         end else begin
            e = digest_q.pop_front();
            if (rsp_digest_word !== e.word) begin
               $error("digest_word expected %h got %h", e.word, rsp_digest_word);
               errors++;
            end
            if (rsp_word_index !== e.index) begin
               $error("word_index expected %0d got %0d", e.index, rsp_word_index);
               errors++;
            end
            if (rsp_last_word !== e.last) begin
               $error("last_word expected %b got %b", e.last, rsp_last_word);
               errors++;
            end
            if (rsp_digest_matches !== e.match_flag) begin
               $error("digest_matches expected %b got %b", e.match_flag,
                      rsp_digest_matches);
               errors++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_beat(logic [7:0] b, logic has, logic last);
      if (req_valid && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end else if (!req_valid && gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_message_byte <= b;
      req_has_byte     <= has;
      req_last_byte    <= last;
      do @(posedge clock); while (req_stall);
      predict_digest(b, has, last);
      if (has || last) beats_sent++;
   endtask

   task automatic end_stimulus();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // bytes of msg with occasional empty beats, then either last on the final byte or a separate empty last beat
   task automatic send_message(logic [7:0] msg[$], bit empty_last);
      for (int i = 0; i < msg.size(); i++) begin
         if ($urandom_range(99) < 5) send_beat(8'($urandom), 1'b0, 1'b0);
         send_beat(msg[i], 1'b1, !empty_last && i == msg.size() - 1);
      end
      if (empty_last || msg.size() == 0) send_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_idle();
      end_stimulus();
      while (digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [63:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      expected_st[idx] = data;
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_expected(logic [63:0] d0, logic [63:0] d1, logic [63:0] d2,
                               logic [63:0] d3);
      write_reg(REG_DIGEST_0, d0);
      write_reg(REG_DIGEST_1, d1);
      write_reg(REG_DIGEST_2, d2);
      write_reg(REG_DIGEST_3, d3);
   endtask

   task automatic test_directed();
      logic [7:0] msg[$];
      send_beat(8'hff, 1'b0, 1'b1);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'h00, 1'b1, 1'b1);
      send_beat(8'hff, 1'b1, 1'b1);
      msg = '{8'h61, 8'h62, 8'h63};
      send_message(msg, 1'b0);
      send_message(msg, 1'b1);
      send_beat(8'h5a, 1'b0, 1'b0);
      send_beat(8'ha5, 1'b1, 1'b0);
      send_beat(8'h00, 1'b0, 1'b1);
      wait_idle();
   endtask

   // program the registers with a known digest, then flip single bits
   task automatic test_match();
      logic [7:0] msg[$];
      logic [63:0] d[4];
      for (int i = 0; i < 12; i++) msg.push_back(8'($urandom));
      send_message(msg, 1'b0);
      wait_idle();
      for (int i = 0; i < 4; i++) d[i] = {last_digest[2*i], last_digest[2*i+1]};
      set_expected(d[0], d[1], d[2], d[3]);
      send_message(msg, 1'b0);
      wait_idle();
      set_expected(d[0], d[1], d[2], d[3] ^ 64'h1);
      send_message(msg, 1'b1);
      wait_idle();
      set_expected(d[0] ^ 64'h8000_0000_0000_0000, d[1], d[2], d[3]);
      send_message(msg, 1'b0);
      wait_idle();
   endtask

   task automatic test_random(int gap, int stall, int target);
      logic [7:0] msg[$];
      int len;
      int edge_lens[8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      int stop_at;
      gap_pct = gap;
      stall_pct = stall;
      stop_at = beats_sent + target;
      while (beats_sent < stop_at) begin
         msg = {};
         if ($urandom_range(99) < 25) len = edge_lens[$urandom_range(7)];
         else len = $urandom_range(0, 20);
         for (int i = 0; i < len; i++) msg.push_back(8'($urandom));
         send_message(msg, $urandom_range(1));
      end
      wait_idle();
   endtask

   initial begin
      restart_hash();
      for (int i = 0; i < 4; i++) expected_st[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_match();
      set_expected('0, '0, '0, '0);
      test_random(0, 0, 55);
      set_expected('1, '1, '1, '1);
      test_random(45, 0, 55);
      set_expected({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom});
      test_random(0, 45, 55);
      test_random(25, 25, 55);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

/* sha256_digest_check_core.f */
+incdir+sv
sv/sdc_pkg.sv
sv/sha256_digest_check_core.sv
sv/sdc_checker.sv
dv/tb.sv
